[design/rbpe_pkg.sv]
// Shared types and constants for the rotated blit pixel engine.
// Item structs, operation and register-index codes, reset values.
// No dependencies.
package rbpe_pkg;

    localparam int unsigned SRC_WORDS_DEF = 16384;
    localparam int unsigned FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int unsigned COEF_W  = 18;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned DIM_W   = 12;
    localparam int unsigned PITCH_W = 15;
    localparam int unsigned BASE_W  = 14;
    localparam int unsigned PIX_W   = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 18;

    // Rotation product: 12 x 18 signed
    localparam int unsigned PROD_W = COORD_W + COEF_W;
    // Row offset product: 12 x 15 unsigned
    localparam int unsigned ROWP_W = DIM_W + PITCH_W;
    // Fetch address sum before wrap
    localparam int unsigned FETCH_W = ROWP_W + 1;

    localparam logic signed [COEF_W-1:0] COS_RESET = 18'sh10000;
    localparam logic signed [COEF_W-1:0] SIN_RESET = 18'sh00000;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_BLIT = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS      = 3'd0,
        CFG_SIN      = 3'd1,
        CFG_ANCHOR_X = 3'd2,
        CFG_ANCHOR_Y = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5,
        CFG_STRIDE   = 3'd6,
        CFG_BASE     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        op_t                       operation;
        logic [BASE_W-1:0]         load_address;
        logic [PIX_W-1:0]          load_data;
        logic signed [COORD_W-1:0] rel_x;
        logic signed [COORD_W-1:0] rel_y;
        logic [PIX_W-1:0]          dst_pixel;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic             replaced;
    } out_item_t;

endpackage

[design/rotated_blit_pixel_engine.sv]
// Rotated nearest-neighbor blit engine, top level.
// Holds the source image store, the rotate/clip/fetch pipeline and config registers.
// Depends on rbpe_pkg.

// A load item writes one 32-bit word into the source store and gives no result;
// a blit item rotates its destination offset by the cos/sin registers (signed 2.16 by
// default, FRAC_BITS in general), floors, adds the source anchor, clips against
// the crop width/height and fetches base + y*stride + x (wrapped to the store
// size). A nonzero in-crop source word replaces dst_pixel, else dst_pixel passes.
// Rate: one item per clock, sustained while no result waits under out stall, loads
// and blits mixed freely. A blit passes six registers: input register, rotation
// multipliers, floor and anchor add, clip and row multiplier, address add with
// the store access, pixel select into the output register. The store has one
// write port and one registered read port, both in the same stage; since loads
// write and blits read in that stage in item order, a blit always sees every
// earlier load. The whole pipeline holds while a result waits under out stall.
// SRC_WORDS must be a power of two. The store has no reset; config writes only
// while idle.
module rotated_blit_pixel_engine #(
    parameter int unsigned SRC_WORDS = rbpe_pkg::SRC_WORDS_DEF,
    parameter int unsigned FRAC_BITS = rbpe_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // item input
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  rbpe_pkg::in_item_t                    in_item,
    // result output
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output rbpe_pkg::out_item_t                   out_item,
    // config writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rbpe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rbpe_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int unsigned AW = $clog2(SRC_WORDS);
    // load address, widened when the store is larger than the field
    localparam int unsigned LW = (AW > rbpe_pkg::BASE_W) ? AW : rbpe_pkg::BASE_W;
    // rotated sum and floored coordinate widths
    localparam int unsigned SUM_W = rbpe_pkg::PROD_W + 1;
    localparam int unsigned FLR_W = SUM_W - FRAC_BITS;
    localparam int unsigned SW    = ((FLR_W > rbpe_pkg::COORD_W) ? FLR_W
                                     : rbpe_pkg::COORD_W) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [rbpe_pkg::COEF_W-1:0]  cos_reg, sin_reg;
    logic signed [rbpe_pkg::COORD_W-1:0] anchor_x_reg, anchor_y_reg;
    logic [rbpe_pkg::DIM_W-1:0]          width_reg, height_reg;
    logic [rbpe_pkg::PITCH_W-1:0]        stride_reg;
    logic [rbpe_pkg::BASE_W-1:0]         base_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg      <= rbpe_pkg::COS_RESET;
            sin_reg      <= rbpe_pkg::SIN_RESET;
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            stride_reg   <= '0;
            base_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rbpe_pkg::cfg_idx_t'(cfg_index))
                rbpe_pkg::CFG_COS:      cos_reg      <= $signed(cfg_data);
                rbpe_pkg::CFG_SIN:      sin_reg      <= $signed(cfg_data);
                rbpe_pkg::CFG_ANCHOR_X: anchor_x_reg <= $signed(cfg_data[rbpe_pkg::COORD_W-1:0]);
                rbpe_pkg::CFG_ANCHOR_Y: anchor_y_reg <= $signed(cfg_data[rbpe_pkg::COORD_W-1:0]);
                rbpe_pkg::CFG_WIDTH:    width_reg    <= cfg_data[rbpe_pkg::DIM_W-1:0];
                rbpe_pkg::CFG_HEIGHT:   height_reg   <= cfg_data[rbpe_pkg::DIM_W-1:0];
                rbpe_pkg::CFG_STRIDE:   stride_reg   <= cfg_data[rbpe_pkg::PITCH_W-1:0];
                rbpe_pkg::CFG_BASE:     base_reg     <= cfg_data[rbpe_pkg::BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together unless a result is
    // waiting under stall.
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic adv;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Stage 1: registered input item
    logic                  s1_valid_reg;
    rbpe_pkg::in_item_t    s1_item_reg;

    // Stage 2: rotation products
    logic                                s2_valid_reg;
    rbpe_pkg::op_t                       s2_op_reg;
    logic [rbpe_pkg::BASE_W-1:0]         s2_laddr_reg;
    logic [rbpe_pkg::PIX_W-1:0]          s2_data_reg;   // load data or dst pixel
    logic signed [rbpe_pkg::PROD_W-1:0]  s2_xc_reg, s2_ys_reg, s2_yc_reg, s2_xs_reg;

    // Stage 3: source coordinates
    logic                        s3_valid_reg;
    rbpe_pkg::op_t               s3_op_reg;
    logic [rbpe_pkg::BASE_W-1:0] s3_laddr_reg;
    logic [rbpe_pkg::PIX_W-1:0]  s3_data_reg;
    logic signed [SW-1:0]        s3_sx_reg, s3_sy_reg;

    // Stage 4: clip result and row offset
    logic                        s4_valid_reg;
    rbpe_pkg::op_t               s4_op_reg;
    logic [rbpe_pkg::BASE_W-1:0] s4_laddr_reg;
    logic [rbpe_pkg::PIX_W-1:0]  s4_data_reg;
    logic                        s4_hit_reg;
    logic [rbpe_pkg::ROWP_W-1:0] s4_rowp_reg;
    logic [rbpe_pkg::DIM_W-1:0]  s4_sx_reg;

    // Stage 5: store read data returns
    logic                        s5_valid_reg;
    rbpe_pkg::op_t               s5_op_reg;
    logic [rbpe_pkg::PIX_W-1:0]  s5_dst_reg;
    logic                        s5_hit_reg;
    logic [rbpe_pkg::PIX_W-1:0]  rd_data_reg;

    rbpe_pkg::out_item_t out_item_reg;

    // stage 2 -> 3: floor shift and anchor add
    logic signed [SUM_W-1:0] ax_next, ay_next;
    logic signed [SW-1:0]    sx_next, sy_next;

    assign ax_next = SUM_W'(s2_xc_reg) + SUM_W'(s2_ys_reg);
    assign ay_next = SUM_W'(s2_yc_reg) - SUM_W'(s2_xs_reg);
    assign sx_next = SW'($signed(ax_next[SUM_W-1:FRAC_BITS])) + SW'(anchor_x_reg);
    assign sy_next = SW'($signed(ay_next[SUM_W-1:FRAC_BITS])) + SW'(anchor_y_reg);

    // stage 3 -> 4: crop check
    logic sx_ok, sy_ok;

    assign sx_ok = !s3_sx_reg[SW-1] && ({1'b0, s3_sx_reg[SW-2:0]} < SW'(width_reg));
    assign sy_ok = !s3_sy_reg[SW-1] && ({1'b0, s3_sy_reg[SW-2:0]} < SW'(height_reg));

    // stage 4: store addresses, wrapped to the store size
    logic [rbpe_pkg::FETCH_W-1:0] fetch_sum;
    logic [AW-1:0]                fetch_addr;
    logic [LW-1:0]                laddr_wide;
    logic [AW-1:0]                load_addr;

    assign fetch_sum  = rbpe_pkg::FETCH_W'(base_reg) + rbpe_pkg::FETCH_W'(s4_rowp_reg)
                      + rbpe_pkg::FETCH_W'(s4_sx_reg);
    assign fetch_addr = fetch_sum[AW-1:0];
    assign laddr_wide = LW'(s4_laddr_reg);
    assign load_addr  = laddr_wide[AW-1:0];

    // control: valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg && (s5_op_reg == rbpe_pkg::OP_BLIT);
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= in_item;

            s2_op_reg    <= s1_item_reg.operation;
            s2_laddr_reg <= s1_item_reg.load_address;
            s2_data_reg  <= (s1_item_reg.operation == rbpe_pkg::OP_LOAD)
                            ? s1_item_reg.load_data : s1_item_reg.dst_pixel;
            s2_xc_reg    <= s1_item_reg.rel_x * cos_reg;
            s2_ys_reg    <= s1_item_reg.rel_y * sin_reg;
            s2_yc_reg    <= s1_item_reg.rel_y * cos_reg;
            s2_xs_reg    <= s1_item_reg.rel_x * sin_reg;

            s3_op_reg    <= s2_op_reg;
            s3_laddr_reg <= s2_laddr_reg;
            s3_data_reg  <= s2_data_reg;
            s3_sx_reg    <= sx_next;
            s3_sy_reg    <= sy_next;

            s4_op_reg    <= s3_op_reg;
            s4_laddr_reg <= s3_laddr_reg;
            s4_data_reg  <= s3_data_reg;
            s4_hit_reg   <= sx_ok && sy_ok;
            // only meaningful when in the crop, where both fit in 12 bits
            s4_rowp_reg  <= s3_sy_reg[rbpe_pkg::DIM_W-1:0] * stride_reg;
            s4_sx_reg    <= s3_sx_reg[rbpe_pkg::DIM_W-1:0];

            s5_op_reg    <= s4_op_reg;
            s5_dst_reg   <= s4_data_reg;
            s5_hit_reg   <= s4_hit_reg;

            out_item_reg.replaced  <= s5_hit_reg && (rd_data_reg != '0);
            out_item_reg.out_pixel <= (s5_hit_reg && (rd_data_reg != '0))
                                      ? rd_data_reg : s5_dst_reg;
        end
    end

    // ------------------------------------------------------------------
    // Source image store: one write port, one registered read port, both
    // used in stage 4 so item order is kept without forwarding.
    // ------------------------------------------------------------------
    logic [rbpe_pkg::PIX_W-1:0] src_mem [SRC_WORDS];

    always_ff @(posedge clk)
    begin
        if (adv && s4_valid_reg && (s4_op_reg == rbpe_pkg::OP_LOAD))
        begin
            src_mem[load_addr] <= s4_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s4_valid_reg && (s4_op_reg == rbpe_pkg::OP_BLIT))
        begin
            rd_data_reg <= src_mem[fetch_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // load items never surface as results
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s5_valid_reg && (s5_op_reg == rbpe_pkg::OP_LOAD) |=> !out_valid_reg)
        else $error("load item produced a result");

    // a replacing result never carries a zero pixel
    a_replace_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.replaced |-> out_item_reg.out_pixel != '0)
        else $error("replaced result with zero pixel");

    // out-of-crop blit passes the old pixel through unchanged
    a_clip_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s5_valid_reg && (s5_op_reg == rbpe_pkg::OP_BLIT) && !s5_hit_reg
        |=> !out_item_reg.replaced && (out_item_reg.out_pixel == $past(s5_dst_reg)))
        else $error("clipped blit did not pass dst pixel");

    // a blit entering the last stage yields a result on the next edge
    a_blit_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s5_valid_reg && (s5_op_reg == rbpe_pkg::OP_BLIT) |=> out_valid_reg)
        else $error("blit item lost");

endmodule

[tb/sv/rbpe_blit_checker.sv]
// Checker for the rotated blit pixel engine: mirrors config and source store,
// predicts one pixel per accepted blit item and compares accepted results.
// Depends on rbpe_pkg.
module rbpe_blit_checker
    import rbpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_item,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_item,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    // config mirror
    logic signed [COEF_W-1:0]  cos_q;
    logic signed [COEF_W-1:0]  sin_q;
    logic signed [COORD_W-1:0] anchor_x_q;
    logic signed [COORD_W-1:0] anchor_y_q;
    logic [DIM_W-1:0]          width_q;
    logic [DIM_W-1:0]          height_q;
    logic [PITCH_W-1:0]        stride_q;
    logic [BASE_W-1:0]         base_q;

    logic [PIX_W-1:0] src_mirror [SRC_WORDS_DEF];
    out_item_t        expected_pixels [$];
    int               nfail;

    // rotate, floor, add anchor, clip, fetch, pick pixel
    function automatic out_item_t blit_pixel(input logic signed [COORD_W-1:0] rx,
                                             input logic signed [COORD_W-1:0] ry,
                                             input logic [PIX_W-1:0] old);
        logic signed [PROD_W:0] acc_x;
        logic signed [PROD_W:0] acc_y;
        logic signed [PROD_W:0] sx;
        logic signed [PROD_W:0] sy;
        logic [FETCH_W-1:0]     fetch;
        logic [PIX_W-1:0]       word;
        out_item_t              res;
        acc_x = rx * cos_q + ry * sin_q;
        acc_y = ry * cos_q - rx * sin_q;
        sx = (acc_x >>> FRAC_BITS_DEF) + anchor_x_q;
        sy = (acc_y >>> FRAC_BITS_DEF) + anchor_y_q;
        res.out_pixel = old;
        res.replaced  = 1'b0;
        if (sx >= 0 && sx < $signed({1'b0, width_q})
            && sy >= 0 && sy < $signed({1'b0, height_q}))
        begin
            fetch = base_q + sy[DIM_W-1:0] * stride_q + sx[DIM_W-1:0];
            word  = src_mirror[fetch % SRC_WORDS_DEF];
            if (word != '0)
            begin
                res.out_pixel = word;
                res.replaced  = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            cos_q      = COS_RESET;
            sin_q      = SIN_RESET;
            anchor_x_q = '0;
            anchor_y_q = '0;
            width_q    = '0;
            height_q   = '0;
            stride_q   = '0;
            base_q     = '0;
            expected_pixels.delete();
            nfail = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_COS:      cos_q      = cfg_data[COEF_W-1:0];
                    CFG_SIN:      sin_q      = cfg_data[COEF_W-1:0];
                    CFG_ANCHOR_X: anchor_x_q = cfg_data[COORD_W-1:0];
                    CFG_ANCHOR_Y: anchor_y_q = cfg_data[COORD_W-1:0];
                    CFG_WIDTH:    width_q    = cfg_data[DIM_W-1:0];
                    CFG_HEIGHT:   height_q   = cfg_data[DIM_W-1:0];
                    CFG_STRIDE:   stride_q   = cfg_data[PITCH_W-1:0];
                    CFG_BASE:     base_q     = cfg_data[BASE_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (in_item.operation == OP_LOAD)
                    src_mirror[in_item.load_address % SRC_WORDS_DEF] = in_item.load_data;
                else
                    expected_pixels.push_back(blit_pixel(in_item.rel_x, in_item.rel_y,
                                                         in_item.dst_pixel));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (nfail < 10)
                        $display("%0t: unexpected result pixel %h replaced %b",
                                 $time, out_item.out_pixel, out_item.replaced);
                    nfail++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    // four-state compare so an unknown result counts as a miss
                    if (want !== out_item)
                    begin
                        if (nfail < 10)
                            $display({"%0t: expected pixel %h replaced %b, ",
                                      "got pixel %h replaced %b"},
                                     $time, want.out_pixel, want.replaced,
                                     out_item.out_pixel, out_item.replaced);
                        nfail++;
                    end
                end
            end
            mismatches <= nfail;
            pending    <= expected_pixels.size();
        end
    end

endmodule

[tb/sv/tb_rotated_blit_pixel_engine.sv]
// Testbench top for the rotated blit pixel engine: clock, reset, config
// writes, load/blit item stimulus with random idling, and the verdict.
// Depends on rbpe_pkg, rotated_blit_pixel_engine and rbpe_blit_checker.
module tb_rotated_blit_pixel_engine;
    import rbpe_pkg::*;

    // one complete register setting
    typedef struct {
        int cosv;
        int sinv;
        int ax;
        int ay;
        int w;
        int h;
        int stride;
        int base;
    } blit_setup_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item  = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;

    // idling knobs, percent per cycle
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off: toggling hold_trig starts one
    logic hold_trig = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    blit_setup_t setups [7];

    // store words loaded so far; a blit never fetches one that is not
    bit written [SRC_WORDS_DEF];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rotated_blit_pixel_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rbpe_blit_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Hold-off counter runs in its own process so the sender keeps offering
    // items; the six-deep pipeline fills and in_stall must come up.
    always @(posedge clk)
    begin
        if (hold_trig != hold_seen)
        begin
            hold_seen <= hold_trig;
            hold_left <= 300;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver side: random stall plus the long hold-off
    always @(posedge clk)
        out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);

    // Present one item and hold it until accepted. Called at a clock edge,
    // returns at the edge that took the item. Idle gaps go before the item
    // so in_valid is never dropped and raised in the same step.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Load item; the blit fields carry noise the block must ignore.
    function automatic in_item_t make_load(input int addr, input logic [PIX_W-1:0] data);
        in_item_t     it;
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(in_item_t)-1:0];
        it.operation    = OP_LOAD;
        it.load_address = addr[BASE_W-1:0];
        it.load_data    = data;
        return it;
    endfunction

    // Blit item; the load fields carry noise.
    function automatic in_item_t make_blit(input int rx, input int ry,
                                           input logic [PIX_W-1:0] dst);
        in_item_t     it;
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(in_item_t)-1:0];
        it.operation = OP_BLIT;
        it.rel_x     = rx[COORD_W-1:0];
        it.rel_y     = ry[COORD_W-1:0];
        it.dst_pixel = dst;
        return it;
    endfunction

    // Store word a blit under setting s fetches, or -1 when it is clipped.
    function automatic int fetch_index(input blit_setup_t s, input int rx, input int ry);
        longint c;
        longint sn;
        longint ax;
        longint ay;
        longint w;
        longint h;
        longint st;
        longint b;
        longint x;
        longint y;
        longint px;
        longint py;
        c  = longint'($signed(s.cosv[COEF_W-1:0]));
        sn = longint'($signed(s.sinv[COEF_W-1:0]));
        ax = longint'($signed(s.ax[COORD_W-1:0]));
        ay = longint'($signed(s.ay[COORD_W-1:0]));
        w  = longint'(s.w[DIM_W-1:0]);
        h  = longint'(s.h[DIM_W-1:0]);
        st = longint'(s.stride[PITCH_W-1:0]);
        b  = longint'(s.base[BASE_W-1:0]);
        x  = longint'($signed(rx[COORD_W-1:0]));
        y  = longint'($signed(ry[COORD_W-1:0]));
        px = ((x * c + y * sn) >>> FRAC_BITS_DEF) + ax;
        py = ((y * c - x * sn) >>> FRAC_BITS_DEF) + ay;
        if (px < 0 || px >= w || py < 0 || py >= h)
            return -1;
        return int'((b + py * st + px) % longint'(SRC_WORDS_DEF));
    endfunction

    // Load item that also records the word as written.
    task automatic send_load(input int addr, input logic [PIX_W-1:0] data);
        in_item_t it;
        it = make_load(addr, data);
        written[it.load_address] = 1'b1;
        send_item(it);
    endtask

    // Blit item under setting s; when it would fetch a word never loaded,
    // a load of that word goes first. sent gives the items used.
    task automatic send_blit(input blit_setup_t s, input int rx, input int ry,
                             input logic [PIX_W-1:0] dst, output int sent);
        int idx;
        sent = 1;
        idx  = fetch_index(s, rx, ry);
        if (idx >= 0 && !written[idx])
        begin
            send_load(idx, ($urandom_range(0, 5) == 0) ? '0 : $urandom);
            sent = 2;
        end
        send_item(make_blit(rx, ry, dst));
    endtask

    // One register write; cfg_valid stays high for back-to-back writes.
    task automatic put_reg(input cfg_idx_t idx, input int v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_setup(input blit_setup_t s);
        put_reg(CFG_COS,      s.cosv);
        put_reg(CFG_SIN,      s.sinv);
        put_reg(CFG_ANCHOR_X, s.ax);
        put_reg(CFG_ANCHOR_Y, s.ay);
        put_reg(CFG_WIDTH,    s.w);
        put_reg(CFG_HEIGHT,   s.h);
        put_reg(CFG_STRIDE,   s.stride);
        put_reg(CFG_BASE,     s.base);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every expected pixel is out, then let any trailing load
    // items drain through the pipeline (they give no result to wait on).
    task automatic settle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Random mix under setting s. Loads mostly land inside the crop's address
    // window, blits mostly near the anchor, so fetches hit fresh loads and
    // both in-crop and clipped points show up; the rest is full-range noise.
    task automatic random_items(input blit_setup_t s, input int count);
        int win;
        int r;
        int rx;
        int ry;
        int addr;
        int n;
        int sent;
        logic [PIX_W-1:0] data;
        logic [PIX_W-1:0] dst;
        win = (s.stride == 0) ? s.w : s.stride * s.h;
        if (win < 1)
            win = 1;
        if (win > SRC_WORDS_DEF)
            win = SRC_WORDS_DEF;
        r = ((s.w > s.h) ? s.w : s.h) / 2 + 2;
        if (r > 2047)
            r = 2047;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                if ($urandom_range(0, 99) < 70)
                    addr = s.base + $urandom_range(0, win - 1);
                else
                    addr = $urandom_range(0, SRC_WORDS_DEF - 1);
                data = ($urandom_range(0, 5) == 0) ? '0 : $urandom;
                send_load(addr, data);
                n++;
            end
            else
            begin
                if ($urandom_range(0, 99) < 75)
                begin
                    rx = $urandom_range(0, 2 * r) - r;
                    ry = $urandom_range(0, 2 * r) - r;
                end
                else
                begin
                    rx = $urandom_range(0, 4095) - 2048;
                    ry = $urandom_range(0, 4095) - 2048;
                end
                dst = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
                send_blit(s, rx, ry, dst, sent);
                n += sent;
            end
        end
    endtask

    initial
    begin
        #4000000;
        $display("tb_rotated_blit_pixel_engine failed");
        $finish;
    end

    initial
    begin : stimulus
        int ax;
        int ay;
        int w;
        int h;
        int sent;

        // identity, small crop, store origin at 100
        setups[0] = '{65536, 0, 32, 32, 64, 64, 64, 100};
        // quarter turn, crop near the top of the store so fetches wrap
        setups[1] = '{0, 65536, 20, 20, 40, 40, 40, 16300};
        // about 45 degrees with fractional products, zero stride, base 0
        setups[2] = '{46341, 46341, 100, 50, 200, 120, 0, 0};
        // negative unit coefficients, largest crop, stride and base
        setups[3] = '{-65536, -65536, 1000, 1000, 2048, 2048, 16384, 16383};
        // zero width rejects everything; anchor extremes
        setups[4] = '{-46341, 46341, -2048, 2047, 0, 2048, 1, 5};
        // random setting, anchor inside the crop
        w  = $urandom_range(1, 2048);
        h  = $urandom_range(1, 2048);
        ax = $urandom_range(0, w - 1);
        ay = $urandom_range(0, h - 1);
        setups[5] = '{$urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
                      ax, ay, w, h, $urandom_range(0, 16384), $urandom_range(0, 16383)};
        // past the stated ranges: coefficient and dimension field extremes
        setups[6] = '{131071, -131072, 0, 0, 4095, 4095, 32767, 16383};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 7; k++)
        begin
            // sender idles lightly first, then heavily, then not at all
            if (k < 2)
            begin
                send_idle_pct  <= 10;
                recv_stall_pct <= 46;
            end
            else if (k < 4)
            begin
                send_idle_pct  <= 46;
                recv_stall_pct <= 10;
            end
            else
            begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 0;
            end
            write_setup(setups[k]);

            if (k == 0)
            begin
                // Directed: crop center is word 100 + 32*64 + 32 = 2180.
                // Blit right behind a load of the word it fetches.
                send_load(2180, 32'hDEADBEEF);
                send_blit(setups[0], 0, 0, 32'h12345678, sent);
                // zero source word passes the old pixel
                send_load(2180, 32'h00000000);
                send_blit(setups[0], 0, 0, 32'hFFFFFFFF, sent);
                // first and last crop corners
                send_load(100, 32'hFFFFFFFF);
                send_blit(setups[0], -32, -32, 32'h00000000, sent);
                send_load(4195, 32'h00000001);
                send_blit(setups[0], 31, 31, 32'hFFFFFFFF, sent);
                // one step past each crop edge
                send_blit(setups[0], -33, 0, 32'hA5A5A5A5, sent);
                send_blit(setups[0], 32, 0, 32'h5A5A5A5A, sent);
                send_blit(setups[0], 0, -33, 32'h00000000, sent);
                send_blit(setups[0], 0, 32, 32'hFFFFFFFF, sent);
                // offset extremes
                send_blit(setups[0], -2048, -2048, 32'h00000000, sent);
                send_blit(setups[0], 2047, 2047, 32'hFFFFFFFF, sent);
                send_blit(setups[0], -2048, 2047, 32'h00000000, sent);
                send_blit(setups[0], 2047, -2048, 32'hFFFFFFFF, sent);
                // address extremes
                send_load(16383, 32'hFFFFFFFF);
                send_load(0, 32'h80000000);
            end

            // long receiver hold-off while items keep coming
            if (k == 4)
                hold_trig <= ~hold_trig;

            random_items(setups[k], 185);
            in_valid <= 1'b0;
            settle();
        end

        if (mismatches == 0 && pending == 0)
            $display("tb_rotated_blit_pixel_engine passed");
        else
            $display("tb_rotated_blit_pixel_engine failed");
        $finish;
    end

endmodule
